// ===== rtl/core/slim_pkg.sv =====
// Shared types and constants for the sorted list insert/merge unit.
// Used by slim_cell, slim_list and sorted_list_insert_merge_unit; no dependencies.
package slim_pkg;

  localparam int unsigned ListDepth = 32;

  localparam logic [1:0] REQ_INSERT_A = 2'd0;
  localparam logic [1:0] REQ_INSERT_B = 2'd1;
  localparam logic [1:0] REQ_MERGE    = 2'd2;

  localparam logic [1:0] STATUS_INSERTED = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_MERGED   = 2'd2;
  localparam logic [1:0] STATUS_EMPTY    = 2'd3;

  localparam logic SOURCE_A = 1'b0;
  localparam logic SOURCE_B = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
  } slim_in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic               source;
    logic [1:0]         status;
    logic               last;
  } slim_out_t;

  // Command broadcast to every cell of one list.
  typedef struct packed {
    logic               ins;
    logic               pop;
    logic signed [31:0] value;
  } slim_cmd_t;

  // What a cell shows to its two neighbors.
  typedef struct packed {
    logic signed [31:0] data;
    logic               valid;
    logic               gt;
  } slim_link_t;

endpackage

// ===== rtl/core/slim_cell.sv =====
// One storage cell of a sorted list: holds one entry and trades it with its neighbors.
// Depends on slim_pkg.
module slim_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  slim_pkg::slim_cmd_t cmd,
  input  slim_pkg::slim_link_t prev_link,
  input  slim_pkg::slim_link_t next_link,
  output slim_pkg::slim_link_t link
);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;
  logic               valid_r;
  logic               valid_nxt;
  logic               gt;

  // Entries are ascending, so the cells holding values above the new one form a tail.
  assign gt = valid_r && (data_r > cmd.value);

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (cmd.ins) begin
      if (gt || (!valid_r && prev_link.valid)) begin
        data_nxt  = prev_link.gt ? prev_link.data : cmd.value;
        valid_nxt = 1'b1;
      end
    end else if (cmd.pop) begin
      data_nxt  = next_link.data;
      valid_nxt = next_link.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link.data  = data_r;
  assign link.valid = valid_r;
  assign link.gt    = gt;

endmodule

// ===== rtl/core/slim_list.sv =====
// One bounded ascending list built as a chain of slim_cell instances.
// Depends on slim_pkg and slim_cell.
module slim_list (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slim_pkg::slim_cmd_t  cmd,
  output slim_pkg::slim_link_t head,
  output logic                 second_valid,
  output logic                 full
);

  localparam int unsigned Depth = slim_pkg::ListDepth;

  slim_pkg::slim_link_t links [Depth];
  slim_pkg::slim_link_t first_prev;
  slim_pkg::slim_link_t last_next;

  // The front cell always sees a valid neighbor that is not greater.
  assign first_prev.data  = '0;
  assign first_prev.valid = 1'b1;
  assign first_prev.gt    = 1'b0;

  assign last_next.data  = '0;
  assign last_next.valid = 1'b0;
  assign last_next.gt    = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    slim_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .prev_link ((i == 0) ? first_prev : links[(i == 0) ? 0 : i - 1]),
      .next_link ((i == Depth - 1) ? last_next : links[(i == Depth - 1) ? i : i + 1]),
      .link      (links[i])
    );
  end

  assign head         = links[0];
  assign second_valid = links[1].valid;
  assign full         = links[Depth - 1].valid;

endmodule

// ===== rtl/core/sorted_list_insert_merge_unit.sv =====
// Top level of the sorted list insert/merge unit.
// Depends on slim_pkg and slim_list.
//
// Usage: requests arrive on in_valid/in_ready/in_data. An insert into list A
// or B returns one status transfer (inserted or full) on out_valid/out_ready/
// out_data, registered in the cycle after the request transfer. A merge
// returns every entry of both lists in ascending order, A first on equal
// values, one transfer per cycle while out_ready is high, with last set on
// the final one; both lists are empty afterwards. Merging two empty lists
// returns a single empty status transfer. An insert is done by the compare
// in every cell of the list chain; a merge is the request transfer and then
// one head pop per cycle while out_ready allows, its first result loaded
// into the output register after merging_r is set. No request is taken
// while a merge is streaming. Selector code 3 is taken and ignored.
// Reset (rst_n low, synchronous) empties both lists and the output register.
// When the receiver holds out_ready low the output register keeps its item,
// the merge stops and new requests wait.
module sorted_list_insert_merge_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slim_pkg::slim_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output slim_pkg::slim_out_t out_data
);

  slim_pkg::slim_cmd_t  cmd_a;
  slim_pkg::slim_cmd_t  cmd_b;
  slim_pkg::slim_link_t head_a;
  slim_pkg::slim_link_t head_b;
  logic                 second_a;
  logic                 second_b;
  logic                 full_a;
  logic                 full_b;

  logic                 merging_r;
  logic                 merging_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  slim_pkg::slim_out_t  out_data_r;
  slim_pkg::slim_out_t  out_data_nxt;

  logic                 load_ok;
  logic                 in_xfer;
  logic                 take_a;

  assign load_ok  = !out_valid_r || out_ready;
  assign in_ready = !merging_r && load_ok;
  assign in_xfer  = in_valid && in_ready;

  assign take_a = head_a.valid && (!head_b.valid || (head_a.data <= head_b.data));

  always_comb begin
    cmd_a.ins   = 1'b0;
    cmd_a.pop   = 1'b0;
    cmd_a.value = in_data.value;
    cmd_b.ins   = 1'b0;
    cmd_b.pop   = 1'b0;
    cmd_b.value = in_data.value;

    merging_nxt   = merging_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (merging_r && load_ok) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = slim_pkg::STATUS_MERGED;
      if (take_a) begin
        cmd_a.pop              = 1'b1;
        out_data_nxt.value_out = head_a.data;
        out_data_nxt.source    = slim_pkg::SOURCE_A;
        out_data_nxt.last      = !second_a && !head_b.valid;
      end else begin
        cmd_b.pop              = 1'b1;
        out_data_nxt.value_out = head_b.data;
        out_data_nxt.source    = slim_pkg::SOURCE_B;
        out_data_nxt.last      = !second_b && !head_a.valid;
      end
      merging_nxt = !out_data_nxt.last;
    end else if (in_xfer) begin
      out_data_nxt.value_out = '0;
      out_data_nxt.source    = slim_pkg::SOURCE_A;
      out_data_nxt.last      = 1'b1;
      case (in_data.req_type)
        slim_pkg::REQ_INSERT_A: begin
          out_valid_nxt       = 1'b1;
          cmd_a.ins           = !full_a;
          out_data_nxt.status = full_a ? slim_pkg::STATUS_FULL : slim_pkg::STATUS_INSERTED;
        end
        slim_pkg::REQ_INSERT_B: begin
          out_valid_nxt       = 1'b1;
          cmd_b.ins           = !full_b;
          out_data_nxt.status = full_b ? slim_pkg::STATUS_FULL : slim_pkg::STATUS_INSERTED;
        end
        slim_pkg::REQ_MERGE: begin
          if (head_a.valid || head_b.valid) begin
            merging_nxt = 1'b1;
          end else begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = slim_pkg::STATUS_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merging_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      merging_r   <= merging_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  slim_list u_list_a (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd_a),
    .head         (head_a),
    .second_valid (second_a),
    .full         (full_a)
  );

  slim_list u_list_b (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd_b),
    .head         (head_b),
    .second_valid (second_b),
    .full         (full_b)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A merge in progress always has something left to pop.
  a_merge_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    merging_r |-> (head_a.valid || head_b.valid))
    else $error("merge active with both lists empty");

  // A merged item that is not the final one leaves the merge running.
  a_merge_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == slim_pkg::STATUS_MERGED) && !out_data_r.last)
      |-> merging_r)
    else $error("merge ended before its last item");

  // A successful insert leaves the target list non-empty.
  a_insert_a_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_a.ins |=> head_a.valid)
    else $error("insert into list A left it empty");

  a_insert_b_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_b.ins |=> head_b.valid)
    else $error("insert into list B left it empty");

endmodule

// ===== verif/tb_sorted_list_insert_merge_unit.sv =====
// Self-checking testbench for sorted_list_insert_merge_unit: directed rows, then
// random insert/merge traffic under several idle and stall mixes.
// Depends on slim_pkg and the unit's RTL; keeps its own shadow copy of both lists.
module tb_sorted_list_insert_merge_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned ITEMS_PER_PHASE = 60;

  localparam slim_pkg::slim_out_t INS_OK = '{value_out: 32'sd0,
                                             source: slim_pkg::SOURCE_A,
                                             status: slim_pkg::STATUS_INSERTED,
                                             last: 1'b1};
  localparam slim_pkg::slim_out_t BOTH_EMPTY = '{value_out: 32'sd0,
                                                 source: slim_pkg::SOURCE_A,
                                                 status: slim_pkg::STATUS_EMPTY,
                                                 last: 1'b1};
  localparam slim_pkg::slim_out_t NO_RESULT = '0;

  typedef struct packed {
    slim_pkg::slim_in_t  item;
    logic                typed;
    slim_pkg::slim_out_t want;
  } dir_row_t;

  // Rows with typed results carry their one expected transfer; the rest are
  // checked against the shadow lists.
  localparam int NUM_ROWS = 19;
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{slim_pkg::REQ_MERGE,    32'sd0},        1'b1, BOTH_EMPTY},
    '{'{slim_pkg::REQ_INSERT_A, 32'sh7fffffff}, 1'b1, INS_OK},
    '{'{slim_pkg::REQ_INSERT_A, 32'sh80000000}, 1'b1, INS_OK},
    '{'{slim_pkg::REQ_INSERT_B, 32'sd0},        1'b1, INS_OK},
    '{'{slim_pkg::REQ_INSERT_B, -32'sd1},       1'b1, INS_OK},
    '{'{slim_pkg::REQ_INSERT_A, 32'sd5},        1'b1, INS_OK},
    '{'{slim_pkg::REQ_INSERT_B, 32'sd5},        1'b1, INS_OK},
    '{'{slim_pkg::REQ_INSERT_A, 32'sd5},        1'b1, INS_OK},
    '{'{REQ_UNUSED,             32'sh5a5a5a5a}, 1'b0, NO_RESULT},
    '{'{slim_pkg::REQ_MERGE,    -32'sd1},       1'b0, NO_RESULT},
    '{'{slim_pkg::REQ_MERGE,    32'sh7fffffff}, 1'b1, BOTH_EMPTY},
    '{'{slim_pkg::REQ_INSERT_B, 32'sh7fffffff}, 1'b1, INS_OK},
    '{'{slim_pkg::REQ_INSERT_B, 32'sh7fffffff}, 1'b1, INS_OK},
    '{'{REQ_UNUSED,             32'sh80000000}, 1'b0, NO_RESULT},
    '{'{slim_pkg::REQ_MERGE,    32'sd0},        1'b0, NO_RESULT},
    '{'{slim_pkg::REQ_INSERT_A, 32'sh80000000}, 1'b1, INS_OK},
    '{'{slim_pkg::REQ_INSERT_A, -32'sd7},       1'b1, INS_OK},
    '{'{slim_pkg::REQ_INSERT_A, -32'sd7},       1'b1, INS_OK},
    '{'{slim_pkg::REQ_MERGE,    32'sd0},        1'b0, NO_RESULT}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  slim_pkg::slim_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  slim_pkg::slim_out_t out_data;

  // Shadow contents of list A (index 0) and list B (index 1), ascending.
  logic signed [31:0] held [2][$];
  slim_pkg::slim_out_t step_results[$];
  slim_pkg::slim_out_t pending_results[$];

  int unsigned err_count = 0;
  int unsigned counted_items = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic signed [31:0] recent_value = 32'sd0;

  sorted_list_insert_merge_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Works out the transfers one accepted request causes and updates the shadow lists.
  function automatic void predict_request(input slim_pkg::slim_in_t item);
    int idx;
    int pos;
    int ia;
    int ib;
    int na;
    int nb;
    bit take_a;
    slim_pkg::slim_out_t r;
    step_results.delete();
    case (item.req_type)
      slim_pkg::REQ_INSERT_A, slim_pkg::REQ_INSERT_B: begin
        idx = item.req_type[0];
        r = INS_OK;
        if (held[idx].size() >= slim_pkg::ListDepth) begin
          r.status = slim_pkg::STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < held[idx].size() && held[idx][pos] <= item.value) pos++;
          held[idx].insert(pos, item.value);
        end
        step_results.push_back(r);
      end
      slim_pkg::REQ_MERGE: begin
        na = held[0].size();
        nb = held[1].size();
        if (na + nb == 0) begin
          step_results.push_back(BOTH_EMPTY);
        end else begin
          ia = 0;
          ib = 0;
          while (ia < na || ib < nb) begin
            take_a = (ib >= nb) || (ia < na && held[0][ia] <= held[1][ib]);
            r.value_out = take_a ? held[0][ia] : held[1][ib];
            r.source = take_a ? slim_pkg::SOURCE_A : slim_pkg::SOURCE_B;
            r.status = slim_pkg::STATUS_MERGED;
            r.last = (ia + ib + 1 == na + nb);
            if (take_a) ia++;
            else ib++;
            step_results.push_back(r);
          end
          held[0].delete();
          held[1].delete();
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    int sel;
    logic signed [31:0] v;
    sel = $urandom_range(99);
    if (sel < 55) v = $urandom;
    else if (sel < 70) v = $signed($urandom_range(8)) - 32'sd4;
    else if (sel < 80) v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    else v = recent_value;
    recent_value = v;
    return v;
  endfunction

  // Entered and left at a falling edge. Valid stays high after the transfer
  // until the next call or a pause decides otherwise.
  task automatic send_item(input slim_pkg::slim_in_t item, input logic typed,
                           input slim_pkg::slim_out_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predict_request(item);
    if (typed) pending_results.push_back(want);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
    if (item.req_type != REQ_UNUSED) counted_items++;
    @(negedge clk);
  endtask

  task automatic send_req(input logic [1:0] req, input logic signed [31:0] v);
    slim_pkg::slim_in_t item;
    item.req_type = req;
    item.value = v;
    send_item(item, 1'b0, NO_RESULT);
  endtask

  // The sender holds off until every expected transfer has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic fill_list(input logic [1:0] req, input int n);
    repeat (n) send_req(req, pick_value());
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit with_fill);
    int unsigned start;
    int kind;
    int n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = counted_items;
    if (with_fill) begin
      // Overfill one list so the full status shows up, then drain a deep merge.
      fill_list(slim_pkg::REQ_INSERT_B, slim_pkg::ListDepth + 1);
      fill_list(slim_pkg::REQ_INSERT_A, $urandom_range(slim_pkg::ListDepth + 2, 4));
      send_req(slim_pkg::REQ_MERGE, pick_value());
    end
    while (counted_items - start < ITEMS_PER_PHASE) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        send_req(REQ_UNUSED, $urandom);
      end else if (kind < 11) begin
        send_req(slim_pkg::REQ_MERGE, $urandom);
      end else if (kind < 14) begin
        fill_list($urandom_range(1) ? slim_pkg::REQ_INSERT_B : slim_pkg::REQ_INSERT_A,
                  $urandom_range(slim_pkg::ListDepth + 3, 20));
      end else begin
        n = $urandom_range(12, 1);
        repeat (n) begin
          send_req($urandom_range(1) ? slim_pkg::REQ_INSERT_B : slim_pkg::REQ_INSERT_A,
                   pick_value());
        end
        if ($urandom_range(9) == 0) hold_until_drained();
        send_req(slim_pkg::REQ_MERGE, $urandom);
      end
    end
    hold_until_drained();
  endtask

  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    slim_pkg::slim_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: value_out %0d source %0d status %0d last %0d",
               out_data.value_out, out_data.source, out_data.status, out_data.last);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, out_data.value_out);
          err_count++;
        end
        if (out_data.source !== want.source) begin
          $error("source: expected %0d, got %0d", want.source, out_data.source);
          err_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          err_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          err_count++;
        end
      end
    end
  end

  // Counts cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("sorted_list_insert_merge_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    hold_until_drained();

    run_phase(0, 0, 1'b1);
    run_phase(56, 0, 1'b0);
    run_phase(0, 56, 1'b1);
    run_phase(14, 14, 1'b0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected transfers never arrived", pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("sorted_list_insert_merge_unit: match");
    end else begin
      $display("sorted_list_insert_merge_unit: mismatch");
    end
    $finish;
  end

endmodule
